// ===== rtl/text_console_writer_macros.svh =====
// Assertion macros for the text console writer.
// Used by the top level; depends on nothing else.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TCW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Field widths, character codes, function and register codes, sequencer types.
package tcw_pkg;

    localparam int ROWS_DEFAULT = 25;
    localparam int COLS_DEFAULT = 80;

    localparam int FUNC_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_ATTR  = 1'b0,
        CFG_CLEAR_ATTR = 1'b1
    } t_cfg_idx;

    typedef enum logic [FUNC_W-1:0] {
        F_PUT_CUR = 3'd0,
        F_PUT_AT  = 3'd1,
        F_CLEAR   = 3'd2,
        F_READ    = 3'd3,
        F_SET     = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_ACT,
        S_RDWAIT,
        S_CLEAR,
        S_SCROLL,
        S_DRAIN,
        S_DONE
    } t_state;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic  in_fire;
        t_func func;
        logic  is_newline;
        logic  on_screen;
        logic  col_last;
        logic  row_last;
        logic  walk_last;
        logic  out_free;
    } t_stat;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic calc_pos;
        logic wr_char;
        logic adv_cursor;
        logic set_scrolled;
        logic start_walk;
        logic home_cursor;
        logic place_cursor;
        logic set_bad;
        logic rd_issue;
        logic rd_capture;
        logic clear_step;
        logic scroll_step;
        logic load_out;
    } t_ctrl;

endpackage

// ===== rtl/tcw_in_if.sv =====
// Command channel of the text console writer: valid, ready and one command.
// Depends on tcw_pkg for the field widths.
interface tcw_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::FUNC_W-1:0]    func;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::ROW_W-1:0]     row;
    logic [tcw_pkg::COL_W-1:0]     col;

    modport source(output valid, func, char_code, row, col, input ready);
    modport sink(input valid, func, char_code, row, col, output ready);
endinterface

// ===== rtl/tcw_out_if.sv =====
// Result channel of the text console writer: valid, ready and one status beat.
// Depends on tcw_pkg for the field widths.
interface tcw_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::ROW_W-1:0]     cursor_row;
    logic [tcw_pkg::COL_W-1:0]     cursor_col;
    logic                          scrolled;
    logic [tcw_pkg::CHAR_W-1:0]    read_char;
    logic [tcw_pkg::ATTR_W-1:0]    read_attr;
    logic                          bad_position;

    modport source(output valid, cursor_row, cursor_col, scrolled, read_char, read_attr,
                   bad_position, input ready);
    modport sink(input valid, cursor_row, cursor_col, scrolled, read_char, read_attr,
                 bad_position, output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_fsm.sv =====
// Sequencer of the text console writer: decodes one command over several steps.
// Depends on tcw_pkg for the state, status and strobe types.
module tcw_fsm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_ctrl o_ctrl
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (i_stat.in_fire) n_state = tcw_pkg::S_POS;
            end
            tcw_pkg::S_POS: begin
                n_state = tcw_pkg::S_ACT;
            end
            tcw_pkg::S_ACT: begin
                unique case (i_stat.func) inside
                    tcw_pkg::F_PUT_CUR, tcw_pkg::F_PUT_AT: begin
                        if (i_stat.col_last && i_stat.row_last) n_state = tcw_pkg::S_SCROLL;
                        else n_state = tcw_pkg::S_DONE;
                    end
                    tcw_pkg::F_CLEAR: begin
                        n_state = tcw_pkg::S_CLEAR;
                    end
                    tcw_pkg::F_READ: begin
                        if (i_stat.on_screen) n_state = tcw_pkg::S_RDWAIT;
                        else n_state = tcw_pkg::S_DONE;
                    end
                    default: begin
                        n_state = tcw_pkg::S_DONE;
                    end
                endcase
            end
            tcw_pkg::S_RDWAIT: begin
                n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_CLEAR: begin
                if (i_stat.walk_last) n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_SCROLL: begin
                if (i_stat.walk_last) n_state = tcw_pkg::S_DRAIN;
            end
            tcw_pkg::S_DRAIN: begin
                n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = tcw_pkg::S_IDLE;
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
            end
            tcw_pkg::S_POS: begin
                o_ctrl.calc_pos = 1'b1;
            end
            tcw_pkg::S_ACT: begin
                unique case (i_stat.func) inside
                    tcw_pkg::F_PUT_CUR, tcw_pkg::F_PUT_AT: begin
                        // newline writes no character; it moves the cursor and may scroll
                        o_ctrl.wr_char    = !i_stat.is_newline;
                        o_ctrl.adv_cursor = 1'b1;
                        if (i_stat.col_last && i_stat.row_last) begin
                            o_ctrl.set_scrolled = 1'b1;
                            o_ctrl.start_walk   = 1'b1;
                        end
                    end
                    tcw_pkg::F_CLEAR: begin
                        o_ctrl.start_walk  = 1'b1;
                        o_ctrl.home_cursor = 1'b1;
                    end
                    tcw_pkg::F_READ: begin
                        o_ctrl.rd_issue = i_stat.on_screen;
                        o_ctrl.set_bad  = !i_stat.on_screen;
                    end
                    tcw_pkg::F_SET: begin
                        o_ctrl.place_cursor = i_stat.on_screen;
                        o_ctrl.set_bad      = !i_stat.on_screen;
                    end
                    default: begin
                        o_ctrl.in_ready = 1'b0;
                    end
                endcase
            end
            tcw_pkg::S_RDWAIT: begin
                o_ctrl.rd_capture = 1'b1;
            end
            tcw_pkg::S_CLEAR: begin
                o_ctrl.clear_step = 1'b1;
            end
            tcw_pkg::S_SCROLL: begin
                o_ctrl.scroll_step = 1'b1;
            end
            tcw_pkg::S_DRAIN: begin
                o_ctrl.in_ready = 1'b0;
            end
            tcw_pkg::S_DONE: begin
                o_ctrl.load_out = i_stat.out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer top level: cursor, position datapath, screen store, result register.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ram, tcw_fsm and the macro header.
//
// One command beat is taken at a time. A put-char that does not scroll, set-cursor, unused
// codes and an off-screen read pass through position, action and result load before the next
// accept; an on-screen read-cell adds a wait step, since the screen store read is registered.
// Clear and a put-char that scrolls walk every cell of the screen, the scroll followed by a
// drain step: the walk counter visits one cell per cycle through the single write port of the
// screen store, a scroll reading the cell one row below and writing it in the next cycle. The
// store gets no clearing pass after reset and holds garbage until written, so issue a clear
// before the first read or scroll. A finished result waits in the output register while the
// next command is already taken. Configuration writes are taken at any time but are meant
// for when the block is idle.
`include "text_console_writer_macros.svh"

module text_console_writer #(
    parameter int SCREEN_ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int SCREEN_COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tcw_in_if.sink                         i_in,
    tcw_out_if.source                      o_out
);

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int AW    = $clog2(CELLS);

    localparam logic [RW-1:0] ROW_LAST      = RW'(SCREEN_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST      = CW'(SCREEN_COLS - 1);
    localparam logic [6:0]    ROWS_LIMIT    = 7'(SCREEN_ROWS);
    localparam logic [8:0]    COLS_LIMIT    = 9'(SCREEN_COLS);
    localparam logic [AW-1:0] COLS_A        = AW'(SCREEN_COLS);
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'((SCREEN_ROWS - 1) * SCREEN_COLS);
    localparam logic [AW-1:0] CELL_LAST     = AW'(CELLS - 1);

    tcw_pkg::t_ctrl ctrl;
    tcw_pkg::t_stat stat;
    logic           in_fire;

    // configuration
    logic [tcw_pkg::ATTR_W-1:0] r_text_attr;
    logic [tcw_pkg::ATTR_W-1:0] r_clear_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr  <= tcw_pkg::ATTR_RESET;
            r_clear_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            unique case (tcw_pkg::t_cfg_idx'(i_cfg_idx))
                tcw_pkg::CFG_TEXT_ATTR:  r_text_attr  <= i_cfg_data;
                tcw_pkg::CFG_CLEAR_ATTR: r_clear_attr <= i_cfg_data;
                default:                 r_text_attr  <= r_text_attr;
            endcase
        end
    end

    // command capture
    tcw_pkg::t_func              r_func;
    logic [tcw_pkg::CHAR_W-1:0]  r_char;
    logic [tcw_pkg::ROW_W-1:0]   r_row_in;
    logic [tcw_pkg::COL_W-1:0]   r_col_in;

    assign in_fire    = i_in.valid && ctrl.in_ready;
    assign i_in.ready = ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func   <= tcw_pkg::t_func'(i_in.func);
            r_char   <= i_in.char_code;
            r_row_in <= i_in.row;
            r_col_in <= i_in.col;
        end
    end

    // position: target cell and its linear address
    logic [RW-1:0]    r_cur_row, n_cur_row;
    logic [CW-1:0]    r_cur_col, n_cur_col;
    logic [RW-1:0]    r_pos_row;
    logic [CW-1:0]    r_pos_col;
    logic [AW-1:0]    r_addr;
    logic             r_onscr;
    logic             in_onscr;
    logic             is_put;
    logic             use_in;
    logic [RW+4:0]    row_in_ext;
    logic [CW+6:0]    col_in_ext;
    logic [RW-1:0]    sel_row;
    logic [CW-1:0]    sel_col;
    logic [AW-1:0]    pos_addr;

    always_comb begin
        in_onscr   = ({2'b00, r_row_in} < ROWS_LIMIT) && ({2'b00, r_col_in} < COLS_LIMIT);
        is_put     = (r_func == tcw_pkg::F_PUT_CUR) || (r_func == tcw_pkg::F_PUT_AT);
        use_in     = ((r_func == tcw_pkg::F_PUT_AT) && in_onscr)
                     || (r_func == tcw_pkg::F_READ) || (r_func == tcw_pkg::F_SET);
        row_in_ext = {RW'(0), r_row_in};
        col_in_ext = {CW'(0), r_col_in};
        sel_row    = use_in ? row_in_ext[RW-1:0] : r_cur_row;
        sel_col    = use_in ? col_in_ext[CW-1:0] : r_cur_col;
        // newline acts as if the last cell of the row were written
        if (is_put && (r_char == tcw_pkg::NEWLINE_CODE)) sel_col = COL_LAST;
        pos_addr   = AW'(sel_row) * COLS_A + AW'(sel_col);
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.calc_pos) begin
            r_pos_row <= sel_row;
            r_pos_col <= sel_col;
            r_addr    <= pos_addr;
            r_onscr   <= in_onscr;
        end
    end

    // cursor
    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        if (ctrl.adv_cursor) begin
            if (r_pos_col != COL_LAST) begin
                n_cur_row = r_pos_row;
                n_cur_col = r_pos_col + CW'(1);
            end else begin
                // past the last row: stay on it, the scroll makes room
                n_cur_row = (r_pos_row == ROW_LAST) ? r_pos_row : r_pos_row + RW'(1);
                n_cur_col = '0;
            end
        end
        if (ctrl.home_cursor) begin
            n_cur_row = '0;
            n_cur_col = '0;
        end
        if (ctrl.place_cursor) begin
            n_cur_row = r_pos_row;
            n_cur_col = r_pos_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else begin
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
        end
    end

    // walk counter shared by clear and scroll
    logic [AW-1:0] r_walk;
    logic [AW-1:0] scroll_raddr;

    always_ff @(posedge i_clk) begin
        if (ctrl.start_walk) begin
            r_walk <= '0;
        end else if (ctrl.clear_step || ctrl.scroll_step) begin
            r_walk <= r_walk + AW'(1);
        end
    end

    // rows above the last copy from one row below; the last row rereads itself
    assign scroll_raddr = (r_walk < LAST_ROW_BASE) ? r_walk + COLS_A : r_walk;

    // scroll write lands in the cycle after its read
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    logic          r_wr_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= ctrl.scroll_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.scroll_step) begin
            r_wr_addr <= r_walk;
            r_wr_zero <= (r_walk >= LAST_ROW_BASE);
        end
    end

    // screen store: {char, attr} per cell
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {r_char, r_text_attr};
        if (r_wr_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_wr_addr;
            // last row: drop the character, keep the attribute
            ram_wdata = r_wr_zero ? {{tcw_pkg::CHAR_W{1'b0}}, ram_rdata[tcw_pkg::ATTR_W-1:0]}
                                  : ram_rdata;
        end else if (ctrl.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_walk;
            ram_wdata = {tcw_pkg::SPACE_CODE, r_clear_attr};
        end else if (ctrl.wr_char) begin
            ram_we    = 1'b1;
        end
        ram_re    = ctrl.rd_issue || ctrl.scroll_step;
        ram_raddr = ctrl.rd_issue ? r_addr : scroll_raddr;
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // per-command result flags
    logic                        r_scrolled;
    logic                        r_bad;
    logic [tcw_pkg::CHAR_W-1:0]  r_rd_char;
    logic [tcw_pkg::ATTR_W-1:0]  r_rd_attr;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_scrolled <= 1'b0;
            r_bad      <= 1'b0;
            r_rd_char  <= '0;
            r_rd_attr  <= '0;
        end else begin
            if (ctrl.set_scrolled) r_scrolled <= 1'b1;
            if (ctrl.set_bad) r_bad <= 1'b1;
            if (ctrl.rd_capture) begin
                r_rd_char <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::ATTR_W];
                r_rd_attr <= ram_rdata[tcw_pkg::ATTR_W-1:0];
            end
        end
    end

    // result register
    logic                        r_out_vld;
    logic [tcw_pkg::ROW_W-1:0]   r_o_row;
    logic [tcw_pkg::COL_W-1:0]   r_o_col;
    logic                        r_o_scrolled;
    logic [tcw_pkg::CHAR_W-1:0]  r_o_char;
    logic [tcw_pkg::ATTR_W-1:0]  r_o_attr;
    logic                        r_o_bad;
    logic [RW+4:0]               cur_row_ext;
    logic [CW+6:0]               cur_col_ext;

    assign cur_row_ext = {5'b0, r_cur_row};
    assign cur_col_ext = {7'b0, r_cur_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctrl.load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_out) begin
            r_o_row      <= cur_row_ext[tcw_pkg::ROW_W-1:0];
            r_o_col      <= cur_col_ext[tcw_pkg::COL_W-1:0];
            r_o_scrolled <= r_scrolled;
            r_o_char     <= r_rd_char;
            r_o_attr     <= r_rd_attr;
            r_o_bad      <= r_bad;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.cursor_row   = r_o_row;
    assign o_out.cursor_col   = r_o_col;
    assign o_out.scrolled     = r_o_scrolled;
    assign o_out.read_char    = r_o_char;
    assign o_out.read_attr    = r_o_attr;
    assign o_out.bad_position = r_o_bad;

    // sequencer
    always_comb begin
        stat.in_fire    = in_fire;
        stat.func       = r_func;
        stat.is_newline = (r_char == tcw_pkg::NEWLINE_CODE);
        stat.on_screen  = r_onscr;
        stat.col_last   = (r_pos_col == COL_LAST);
        stat.row_last   = (r_pos_row == ROW_LAST);
        stat.walk_last  = (r_walk == CELL_LAST);
        stat.out_free   = !r_out_vld || o_out.ready;
    end

    tcw_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // checks
    `TCW_ASSERT_IMPLIES(a_cursor_on_screen, i_clk, i_rst_n, 1'b1, (r_cur_row <= ROW_LAST) && (r_cur_col <= COL_LAST), "cursor left the screen")
    `TCW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !ctrl.in_ready, "second command taken while busy")
    `TCW_ASSERT_IMPLIES(a_no_write_when_idle, i_clk, i_rst_n, ctrl.in_ready, !ram_we, "screen write while idle")
    `TCW_ASSERT_IMPLIES(a_scroll_cursor, i_clk, i_rst_n, ctrl.load_out && r_scrolled, (r_cur_row == ROW_LAST) && (r_cur_col == '0), "scroll left cursor off last row start")

endmodule
